>>> design/dbpp_pkg.sv
// Package for the depth buffered point plotter: opcodes, status codes,
// register indexes and store constants. No dependencies.
`default_nettype none
package dbpp_pkg;
  localparam int unsigned ScreenWidth  = 128;
  localparam int unsigned ScreenHeight = 64;
  localparam int unsigned StoreDepth   = 8192;
  localparam int unsigned AddrW        = 13;
  localparam logic [15:0] DepthEmpty   = 16'hFFFF;

  localparam logic [1:0] OpPlot  = 2'd0;
  localparam logic [1:0] OpClear = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;

  localparam logic [2:0] StPlotted = 3'd0;
  localparam logic [2:0] StOff     = 3'd1;
  localparam logic [2:0] StHidden  = 3'd2;
  localparam logic [2:0] StCleared = 3'd3;
  localparam logic [2:0] StRead    = 3'd4;

  localparam logic [2:0] RegNear = 3'd0;
  localparam logic [2:0] RegOffX = 3'd1;
  localparam logic [2:0] RegOffY = 3'd2;
  localparam logic [2:0] RegOffZ = 3'd3;
  localparam logic [2:0] RegFg   = 3'd4;
  localparam logic [2:0] RegBg   = 3'd5;

  // Request to the store: read or write one entry.
  typedef struct packed {
    logic             rd;
    logic             wr;
    logic [AddrW-1:0] addr;
    logic [7:0]       wchar;
    logic [15:0]      wdepth;
  } mem_req_t;
endpackage
`default_nettype wire

>>> design/dbpp_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing.
`default_nettype none
module dbpp_div #(
  parameter int unsigned NumW = 33,
  parameter int unsigned DenW = 25
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 done_o,
  output logic [NumW-1:0]      quot_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [NumW-1:0] quot_q, quot_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DenW:0]   trial;
  logic            fits;
  logic [DenW:0]   rem_step;
  logic [NumW-1:0] quot_step;

  always_comb begin
    // shift in one bit, subtract when it fits
    trial     = {rem_q[DenW-1:0], quot_q[NumW-1]};
    fits      = (trial >= {1'b0, den_q});
    rem_step  = fits ? (trial - {1'b0, den_q}) : trial;
    quot_step = {quot_q[NumW-2:0], fits};
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = rem_step;
      quot_d = quot_step;
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) den_q <= den_i;
  end

  // final quotient is valid in the done cycle, even when a new divide starts
  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign quot_o = quot_step;
endmodule
`default_nettype wire

>>> design/dbpp_store.sv
// Pixel store: character and depth memories, one port, registered read.
// Depends on dbpp_pkg.
`default_nettype none
module dbpp_store (
  input  wire logic               clk_i,
  input  wire dbpp_pkg::mem_req_t req_i,
  output logic [7:0]              rchar_o,
  output logic [15:0]             rdepth_o
);
  logic [7:0]  chars_mem  [dbpp_pkg::StoreDepth];
  logic [15:0] depths_mem [dbpp_pkg::StoreDepth];

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      chars_mem[req_i.addr]  <= req_i.wchar;
      depths_mem[req_i.addr] <= req_i.wdepth;
    end
    if (req_i.rd) begin
      rchar_o  <= chars_mem[req_i.addr];
      rdepth_o <= depths_mem[req_i.addr];
    end
  end
endmodule
`default_nettype wire

>>> design/depth_buffered_point_plotter.sv
// Top level of the depth buffered point plotter: control sequencer, divider
// and pixel store. Depends on dbpp_pkg, dbpp_div and dbpp_store.
//
// One transaction in, one transaction out, one item at a time. A plot adds the
// world offset, then projects column and row through one shared 33-bit
// restoring divider, then reads and conditionally writes the depth store; a
// point with depth zero or negative skips the divides and the store. A clear
// writes all 8192 entries, one per cycle; the same clearing pass runs after
// reset, and no item is accepted until it ends (configuration writes are taken
// at any time). The result sits in an output register that frees the input
// side once it is taken.
`default_nettype none
module depth_buffered_point_plotter #(
  parameter int unsigned SCREEN_WIDTH  = dbpp_pkg::ScreenWidth,
  parameter int unsigned SCREEN_HEIGHT = dbpp_pkg::ScreenHeight
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tuser: opcode[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  // tdata: vertex_x[15:0], vertex_y[31:16], vertex_z[47:32], read_index[60:48]
  input  wire logic [63:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tuser: status[2:0]
  output logic [2:0]       m_axis_tuser,
  // tdata: pixel_char[7:0], pixel_depth[23:8]
  output logic [23:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  localparam int unsigned AW = dbpp_pkg::AddrW;
  localparam int unsigned NumW = 33;  // near * |w| fits 16+17 bits
  localparam int unsigned DenW = 25;  // wz*256 up to 17+8 bits

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_DIVX  = 7'b0000100,
    S_DIVY  = 7'b0001000,
    S_RMW   = 7'b0010000,
    S_DEC   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [15:0] near_q;
  logic signed [15:0] offx_q, offy_q, offz_q;
  logic [7:0] fg_q, bg_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= 16'd256;
      offx_q <= '0;
      offy_q <= '0;
      offz_q <= '0;
      fg_q   <= 8'd35;
      bg_q   <= 8'd32;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dbpp_pkg::RegNear: near_q <= cfg_data_i;
        dbpp_pkg::RegOffX: offx_q <= cfg_data_i;
        dbpp_pkg::RegOffY: offy_q <= cfg_data_i;
        dbpp_pkg::RegOffZ: offz_q <= cfg_data_i;
        dbpp_pkg::RegFg:   fg_q   <= cfg_data_i[7:0];
        dbpp_pkg::RegBg:   bg_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // item registers
  logic signed [16:0] wy_q, wy_d, wz_q, wz_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [NumW-1:0] col_q, col_d;
  logic [2:0] st_q, st_d;
  logic [7:0] och_q, och_d;
  logic [15:0] odep_q, odep_d;
  logic yneg_q, yneg_d;
  logic clr_last;

  // divider; the divisor is taken from the next-state depth so that a divide
  // started at acceptance sees the new item's depth
  logic div_start, div_done;
  logic [NumW-1:0] div_num, div_quot;
  logic signed [33:0] prod;
  logic signed [16:0] w_sel;
  dbpp_div #(.NumW(NumW), .DenW(DenW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num),
    .den_i({wz_d[15:0], 8'h00}), .done_o(div_done), .quot_o(div_quot)
  );

  dbpp_pkg::mem_req_t req;
  logic [7:0] rchar;
  logic [15:0] rdepth;
  dbpp_store u_store (.clk_i, .req_i(req), .rchar_o(rchar), .rdepth_o(rdepth));

  logic signed [16:0] wx_in, wy_in, wz_in;
  logic [NumW+10:0] idx_full;
  logic col_ok, row_ok;

  assign wx_in = 17'(signed'(s_axis_tdata[15:0])) + 17'(offx_q);
  assign wy_in = 17'(signed'(s_axis_tdata[31:16])) + 17'(offy_q);
  assign wz_in = 17'(signed'(s_axis_tdata[47:32])) + 17'(offz_q);
  assign clr_last = (addr_q == AW'(dbpp_pkg::StoreDepth - 1));
  assign col_ok = (col_q < NumW'(SCREEN_WIDTH));
  assign row_ok = (div_quot < NumW'(SCREEN_HEIGHT));
  assign idx_full = (NumW+11)'(col_q) + (NumW+11)'(div_quot) * (NumW+11)'(SCREEN_WIDTH);
  assign prod = 34'(signed'({1'b0, near_q})) * 34'(w_sel);

  assign s_axis_tready = (state_q == S_IDLE) && !m_axis_tvalid;

  always_comb begin
    state_d = state_q;
    wy_d = wy_q;
    wz_d = wz_q;
    addr_d = addr_q;
    col_d = col_q;
    st_d = st_q;
    och_d = och_q;
    odep_d = odep_q;
    yneg_d = yneg_q;
    div_start = 1'b0;
    w_sel = wy_q;
    div_num = prod[NumW-1:0];
    req = '0;
    case (state_q)
      S_CLEAR: begin
        // sweep the store with background and empty depth
        req.wr = 1'b1;
        req.addr = addr_q;
        req.wchar = bg_q;
        req.wdepth = dbpp_pkg::DepthEmpty;
        addr_d = addr_q + 1'b1;
        if (clr_last) state_d = (st_q == dbpp_pkg::StCleared) ? S_OUT : S_IDLE;
      end
      S_IDLE: begin
        w_sel = wx_in;
        if (s_axis_tvalid && s_axis_tready) begin
          och_d = '0;
          odep_d = '0;
          wy_d = wy_in;
          wz_d = wz_in;
          yneg_d = prod[33] ? 1'b0 : 1'b0;
          case (s_axis_tuser)
            dbpp_pkg::OpPlot: begin
              yneg_d = prod[33];
              if (wz_in <= 0) begin
                st_d = dbpp_pkg::StHidden;
                state_d = S_OUT;
              end else begin
                div_start = 1'b1;
                state_d = S_DIVX;
              end
            end
            dbpp_pkg::OpClear: begin
              st_d = dbpp_pkg::StCleared;
              addr_d = '0;
              state_d = S_CLEAR;
            end
            dbpp_pkg::OpRead: begin
              req.rd = 1'b1;
              req.addr = s_axis_tdata[48 +: AW];
              st_d = dbpp_pkg::StRead;
              state_d = S_DEC;
            end
            default: begin
              st_d = dbpp_pkg::StOff;
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_DIVX: begin
        // yneg_q carries the sign of near*wx until the row divide starts
        if (div_done) begin
          col_d = div_quot;
          st_d = yneg_q ? dbpp_pkg::StOff : dbpp_pkg::StPlotted;
          yneg_d = prod[33];
          div_start = 1'b1;
          state_d = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) begin
          if (yneg_q || st_q == dbpp_pkg::StOff || !col_ok || !row_ok
              || idx_full >= (NumW+11)'(dbpp_pkg::StoreDepth)) begin
            st_d = dbpp_pkg::StOff;
            state_d = S_OUT;
          end else begin
            addr_d = idx_full[AW-1:0];
            req.rd = 1'b1;
            req.addr = idx_full[AW-1:0];
            state_d = S_RMW;
          end
        end
      end
      S_RMW: begin
        // depth compare on read data, write back when strictly nearer
        if ({1'b0, wz_q[15:0]} < {1'b0, rdepth} && wz_q[16] == 1'b0) begin
          req.wr = 1'b1;
          req.addr = addr_q;
          req.wchar = fg_q;
          req.wdepth = wz_q[15:0];
          st_d = dbpp_pkg::StPlotted;
        end else begin
          st_d = dbpp_pkg::StHidden;
        end
        state_d = S_OUT;
      end
      S_DEC: begin
        och_d = rchar;
        odep_d = rdepth;
        state_d = S_OUT;
      end
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  logic ovalid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      addr_q <= '0;
      st_q <= dbpp_pkg::StOff;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q <= addr_d;
      st_q <= st_d;
      if (state_q == S_OUT) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    wy_q <= wy_d;
    wz_q <= wz_d;
    col_q <= col_d;
    och_q <= och_d;
    odep_q <= odep_d;
    yneg_q <= yneg_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser = st_q;
  assign m_axis_tdata = {odep_q, och_q};

  // a new item never arrives while the divider works
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVX || state_q == S_DIVY) |-> !s_axis_tready)
    else $error("input accepted during divide");
  // result register holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  // store writes only from clear or depth update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.wr |-> (state_q == S_CLEAR || state_q == S_RMW))
    else $error("stray store write");
endmodule
`default_nettype wire

>>> tb/depth_buffered_point_plotter_checker.sv
// Checker for the depth buffered point plotter: watches the item, result and
// register channels, predicts every result and compares. Depends on dbpp_pkg.
`default_nettype none
module depth_buffered_point_plotter_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic [63:0] s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [2:0]  m_axis_tuser,
  input  wire logic [23:0] m_axis_tdata,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output int               fail_count_o
);
  import dbpp_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  pchar;
    logic [15:0] pdepth;
  } pixel_result_t;

  logic [15:0]        near_q;
  logic signed [15:0] off_x_q, off_y_q, off_z_q;
  logic [7:0]         fg_q, bg_q;
  logic [7:0]         chars_q [StoreDepth];
  logic [15:0]        depths_q [StoreDepth];
  pixel_result_t      pending_results [$];
  int                 mismatches;

  assign fail_count_o = mismatches + pending_results.size();

  function automatic void clear_pixels();
    for (int i = 0; i < StoreDepth; i++) begin
      chars_q[i]  = bg_q;
      depths_q[i] = DepthEmpty;
    end
  endfunction

  // Floor of near*w/(wz*256), or -1 when negative or not below lim.
  function automatic longint project_axis(int w, int wz, longint lim);
    longint nl, num, q;
    nl  = near_q;
    num = nl * w;
    if (num < 0) return -1;
    q = num / (longint'(wz) * 256);
    return (q >= lim) ? -1 : q;
  endfunction

  function automatic pixel_result_t draw_item(logic [1:0] op, logic [63:0] d);
    pixel_result_t r;
    int wx, wy, wz;
    longint col, row, idx;
    r = '{status: StOff, pchar: 8'd0, pdepth: 16'd0};
    if (op == OpPlot) begin
      wx = int'($signed(d[15:0]))  + int'(off_x_q);
      wy = int'($signed(d[31:16])) + int'(off_y_q);
      wz = int'($signed(d[47:32])) + int'(off_z_q);
      if (wz <= 0) begin
        r.status = StHidden;
      end else begin
        col = project_axis(wx, wz, ScreenWidth);
        row = project_axis(wy, wz, ScreenHeight);
        if (col < 0 || row < 0) begin
          r.status = StOff;
        end else begin
          idx = col + row * ScreenWidth;
          if (idx >= StoreDepth) begin
            r.status = StOff;
          end else if (wz < int'(depths_q[idx])) begin
            chars_q[idx]  = fg_q;
            depths_q[idx] = wz[15:0];
            r.status = StPlotted;
          end else begin
            r.status = StHidden;
          end
        end
      end
    end else if (op == OpClear) begin
      clear_pixels();
      r.status = StCleared;
    end else if (op == OpRead) begin
      r.status = StRead;
      r.pchar  = chars_q[d[60:48]];
      r.pdepth = depths_q[d[60:48]];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_result_t exp_r, got_r;
    if (!rst_ni) begin
      near_q  <= 16'd256;
      off_x_q <= '0;
      off_y_q <= '0;
      off_z_q <= '0;
      fg_q    <= 8'd35;
      bg_q    <= 8'd32;
      for (int i = 0; i < StoreDepth; i++) begin
        chars_q[i]  = 8'd32;
        depths_q[i] = DepthEmpty;
      end
      pending_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegNear: near_q  <= cfg_data_i;
          RegOffX: off_x_q <= cfg_data_i;
          RegOffY: off_y_q <= cfg_data_i;
          RegOffZ: off_z_q <= cfg_data_i;
          RegFg:   fg_q    <= cfg_data_i[7:0];
          RegBg:   bg_q    <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_results.push_back(draw_item(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got_r = '{status: m_axis_tuser, pchar: m_axis_tdata[7:0],
                  pdepth: m_axis_tdata[23:8]};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d char %0d depth %0d",
                     got_r.status, got_r.pchar, got_r.pdepth);
        end else begin
          exp_r = pending_results.pop_front();
          if (got_r !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected status %0d char %0d depth %0d, got %0d %0d %0d",
                       exp_r.status, exp_r.pchar, exp_r.pdepth,
                       got_r.status, got_r.pchar, got_r.pdepth);
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> tb/depth_buffered_point_plotter_tb.sv
// Top of the plotter testbench: clock, reset, stimulus and verdict.
// Depends on dbpp_pkg, the plotter and depth_buffered_point_plotter_checker.
`default_nettype none
module depth_buffered_point_plotter_tb;
  localparam int IdleLimit = 40000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = '0;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [2:0]  m_axis_tuser;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  int          fail_count;

  // Stimulus-side bookkeeping.
  int          items_in, results_out, idle_cycles;
  bit          sink_steady, sender_steady;
  int          holdoff_request;
  logic [15:0] near_cur;
  logic signed [15:0] offx_cur, offy_cur, offz_cur;

  always #5 clk_i = ~clk_i;

  depth_buffered_point_plotter uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tuser, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  depth_buffered_point_plotter_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tuser, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count)
  );

  // Count transactions and run the watchdog on cycles with no progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) items_in++;
      if (m_axis_tvalid && m_axis_tready) results_out++;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("depth_buffered_point_plotter_tb: FAIL");
        $finish;
      end
    end
  end

  // Result sink: random stalls, steady stretches, and long hold-offs on request.
  always @(negedge clk_i) begin
    int hold_left;
    if (holdoff_request > 0) begin
      hold_left = holdoff_request;
      holdoff_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= sink_steady ? 1'b1 : ($urandom_range(0, 99) >= 16);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      dbpp_pkg::RegNear: near_cur = val;
      dbpp_pkg::RegOffX: offx_cur = val;
      dbpp_pkg::RegOffY: offy_cur = val;
      dbpp_pkg::RegOffZ: offz_cur = val;
      default: ;
    endcase
  endtask

  // Offer one item; idle first at random, then hold until accepted.
  task automatic send_item(logic [1:0] op, logic [63:0] d);
    @(negedge clk_i);
    while (!sender_steady && $urandom_range(0, 99) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic plot_at(logic [15:0] vx, logic [15:0] vy, logic [15:0] vz);
    send_item(dbpp_pkg::OpPlot, {16'd0, vz, vy, vx});
  endtask

  task automatic read_at(logic [12:0] idx);
    send_item(dbpp_pkg::OpRead, {3'd0, idx, 48'd0});
  endtask

  // Lower valid and wait for every outstanding result.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (items_in == results_out);
  endtask

  // Aim a vertex at a chosen pixel so most random plots land on screen.
  task automatic aimed_plot();
    int wz, col, row;
    longint wx, wy;
    wz  = int'($urandom_range(1, 3000));
    col = ($urandom_range(0, 1)) ? int'($urandom_range(0, 7)) : int'($urandom_range(0, 127));
    row = ($urandom_range(0, 1)) ? int'($urandom_range(0, 3)) : int'($urandom_range(0, 63));
    if (near_cur == 0) begin
      wx = longint'($urandom_range(0, 32767));
      wy = longint'($urandom_range(0, 32767));
    end else begin
      wx = (longint'(col) * wz * 256 + longint'($urandom_range(0, 255))) / near_cur;
      wy = (longint'(row) * wz * 256 + longint'($urandom_range(0, 255))) / near_cur;
    end
    plot_at(16'(wx - offx_cur), 16'(wy - offy_cur), 16'(wz - offz_cur));
  endtask

  task automatic random_item();
    int pick;
    pick = int'($urandom_range(0, 999));
    if (pick < 680) aimed_plot();
    else if (pick < 850) read_at(($urandom_range(0, 1)) ? 13'($urandom_range(0, 600))
                                                        : 13'($urandom_range(0, 8191)));
    else if (pick < 950) plot_at(16'($urandom), 16'($urandom), 16'($urandom));
    else if (pick < 975) send_item(2'd3, {3'd0, 61'($urandom) << 29 ^ 61'($urandom)});
    else if (pick < 985) send_item(dbpp_pkg::OpClear, {3'd0, 61'($urandom)});
    else send_item(2'($urandom), {3'd0, 61'({$urandom, $urandom})});
  endtask

  initial begin
    items_in = 0;
    results_out = 0;
    idle_cycles = 0;
    holdoff_request = 0;
    sink_steady = 1'b0;
    sender_steady = 1'b0;
    near_cur = 16'd256;
    {offx_cur, offy_cur, offz_cur} = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // Hold off until the clearing pass after reset has finished.
    do @(posedge clk_i); while (!s_axis_tready);

    // Directed part under reset settings.
    plot_at(16'd256, 16'd256, 16'd256);          // pixel (1,1) depth 1.0
    plot_at(16'd256, 16'd256, 16'd256);          // equal depth: hidden
    plot_at(16'd128, 16'd128, 16'd128);          // nearer: plotted
    read_at(13'd129);
    plot_at(16'd0, 16'd0, 16'd0);                // depth zero
    plot_at(16'd100, 16'd100, 16'h8000);         // negative depth
    plot_at(16'h8000, 16'd0, 16'd256);           // column negative
    plot_at(16'd0, 16'h8000, 16'd256);           // row negative
    plot_at(16'h7FFF, 16'd0, 16'd1);             // far past the right edge
    plot_at(16'h7FFF, 16'h7FFF, 16'h7FFF);       // near-corner pixel
    plot_at(16'd32512, 16'd16128, 16'd256);      // last pixel of the store
    read_at(13'd8191);
    read_at(13'd0);
    send_item(2'd3, {3'd0, 61'h1FFF_FFFF_FFFF_FFFF});
    send_item(dbpp_pkg::OpClear, 64'd0);
    read_at(13'd129);
    drain();

    // Zero near distance: everything projects to the origin.
    write_reg(dbpp_pkg::RegNear, 16'd0);
    write_reg(dbpp_pkg::RegFg, 16'd0);
    write_reg(3'd6, 16'hFFFF);                   // beyond the map: ignored
    plot_at(16'h7FFF, 16'h7FFF, 16'd200);
    plot_at(16'h8000, 16'h8000, 16'd100);
    read_at(13'd0);
    drain();

    // Random phases with differing settings, extremes first.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin write_reg(dbpp_pkg::RegNear, 16'd256); write_reg(dbpp_pkg::RegFg, 16'd255);
                 write_reg(dbpp_pkg::RegBg, 16'd0); end
        1: begin write_reg(dbpp_pkg::RegNear, 16'hFFFF); write_reg(dbpp_pkg::RegOffX, 16'h7FFF);
                 write_reg(dbpp_pkg::RegOffY, 16'h7FFF); write_reg(dbpp_pkg::RegOffZ, 16'h7FFF);
           end
        2: begin write_reg(dbpp_pkg::RegOffX, 16'h8000); write_reg(dbpp_pkg::RegOffY, 16'h8000);
                 write_reg(dbpp_pkg::RegOffZ, 16'h8000); write_reg(dbpp_pkg::RegBg, 16'd255);
           end
        3: begin write_reg(dbpp_pkg::RegNear, 16'd0); write_reg(dbpp_pkg::RegOffX, 16'd0);
                 write_reg(dbpp_pkg::RegOffY, 16'd0); write_reg(dbpp_pkg::RegOffZ, 16'd0); end
        default: begin
          write_reg(dbpp_pkg::RegNear, 16'($urandom_range(1, 65535)));
          write_reg(dbpp_pkg::RegOffX, $urandom_range(0, 1) ? 16'($urandom) : 16'd0);
          write_reg(dbpp_pkg::RegOffY, $urandom_range(0, 1) ? 16'($urandom) : 16'd0);
          write_reg(dbpp_pkg::RegOffZ, $urandom_range(0, 1) ? 16'($urandom) : 16'd0);
          write_reg(dbpp_pkg::RegFg, 16'($urandom));
          write_reg(dbpp_pkg::RegBg, 16'($urandom));
        end
      endcase
      send_item(dbpp_pkg::OpClear, 64'd0);       // repaint with the new background
      for (int n = 0; n < 160; n++) begin
        if (phase == 4 && n == 20) holdoff_request = 400;
        sink_steady   = (phase == 5 && n >= 40 && n < 120);
        sender_steady = sink_steady;
        random_item();
      end
      sink_steady = 1'b0;
      sender_steady = 1'b0;
      drain();                                   // sender pause until all results are in
    end

    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && items_in == results_out)
      $display("depth_buffered_point_plotter_tb: PASS");
    else
      $display("depth_buffered_point_plotter_tb: FAIL");
    $finish;
  end
endmodule
`default_nettype wire
